/* rtl/core/dmac_pkg.sv */
// Shared constants, codes, controller/datapath command and status types
// for the dual moving average crossover block. No dependencies.
`default_nettype none
package dmac_pkg;
    localparam int MAX_WINDOW = 128;
    localparam int PRICE_W    = 32;
    localparam int WIN_REG_W  = 8;
    localparam int WIN_W      = $clog2(MAX_WINDOW + 1);
    localparam int ADDR_W     = $clog2(MAX_WINDOW);
    localparam int SUM_W      = 39;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 8;
    localparam int DIV_N_W    = 64;
    localparam int DIV_D_W    = 33;
    localparam int DIV_Q_W    = 32;
    localparam int DIV_CNT_W  = $clog2(DIV_Q_W + 1);
    localparam int LVL_W      = 34;

    localparam logic [KIND_W-1:0] CROSS_NONE = 2'd0;
    localparam logic [KIND_W-1:0] CROSS_UP   = 2'd1;
    localparam logic [KIND_W-1:0] CROSS_DOWN = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SHORT_WINDOW = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_WINDOW  = 8'd1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD_S, ST_RD_L, ST_SUMS, ST_DIV_S, ST_WAIT_S, ST_DIV_L,
        ST_WAIT_L, ST_CROSS, ST_PROD, ST_DIV_X, ST_WAIT_X, ST_COMMIT
    } t_state;

    typedef enum logic [1:0] {DIV_SHORT, DIV_LONG, DIV_CROSS} t_div_sel;

    typedef struct packed {
        logic     load_in;
        logic     rd_short;
        logic     rd_long;
        logic     upd_sums;
        logic     div_start;
        t_div_sel div_sel;
        logic     take_quot;
        logic     cross_calc;
        logic     prod_calc;
        logic     commit;
    } t_dp_cmd;

    typedef struct packed {
        logic need_s;
        logic need_l;
        logic need_x;
        logic div_done;
        logic out_free;
    } t_dp_status;
endpackage
`default_nettype wire

/* rtl/core/dmac_ifs.sv */
// Stream and configuration channel interfaces of the crossover block.
// Depends on dmac_pkg for field widths.
`default_nettype none
interface dmac_in_if;
    logic                         valid;
    logic                         ready;
    logic [dmac_pkg::PRICE_W-1:0] price_sample;
    modport source (output valid, output price_sample, input ready);
    modport sink   (input valid, input price_sample, output ready);
endinterface

interface dmac_out_if;
    logic                                valid;
    logic                                ready;
    logic [dmac_pkg::PRICE_W-1:0]        short_average;
    logic [dmac_pkg::PRICE_W-1:0]        long_average;
    logic [dmac_pkg::KIND_W-1:0]         cross_kind;
    logic signed [dmac_pkg::PRICE_W-1:0] cross_value;
    modport source (output valid, output short_average, output long_average,
                    output cross_kind, output cross_value, input ready);
    modport sink   (input valid, input short_average, input long_average,
                    input cross_kind, input cross_value, output ready);
endinterface

interface dmac_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [dmac_pkg::CFG_IDX_W-1:0] index;
    logic [dmac_pkg::WIN_REG_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/dual_moving_average_crossover.sv */
// Top level of the dual moving average crossover block.
// Depends on dmac_pkg, dmac_ifs, dmac_ctrl and dmac_dp.
//
// One price sample per request; one result per sample with the short and
// long averages, the cross kind and the interpolated crossing level. Samples
// are handled one at a time by a sequencer: two delay-line reads, a sum
// update, up to two divisions, a cross step, a multiply and a third
// division; the divisions share one divider that retires one quotient bit
// per cycle. A new sample is taken while the previous result still waits in
// the output register. Configuration writes are always ready, and writes to
// the window registers restart averaging.
`default_nettype none
module dual_moving_average_crossover (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dmac_in_if.sink    i_in,
    dmac_out_if.source o_out,
    dmac_cfg_if.sink   i_cfg
);
    import dmac_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       in_ready;

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    dmac_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    dmac_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_price_sample  (i_in.price_sample),
        .i_cfg_valid     (i_cfg.valid),
        .i_cfg_index     (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_short_average (o_out.short_average),
        .o_long_average  (o_out.long_average),
        .o_cross_kind    (o_out.cross_kind),
        .o_cross_value   (o_out.cross_value)
    );
endmodule
`default_nettype wire

/* rtl/core/dmac_div.sv */
// Restoring divider, one quotient bit per cycle, for quotients known to fit
// in DIV_Q_W bits. Depends on dmac_pkg.
`default_nettype none
module dmac_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [dmac_pkg::DIV_N_W-1:0] i_dividend,
    input  wire logic [dmac_pkg::DIV_D_W-1:0] i_divisor,
    output logic                              o_done,
    output logic [dmac_pkg::DIV_Q_W-1:0]      o_quotient
);
    import dmac_pkg::*;

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_D_W-1:0]   r_rem;
    logic [DIV_Q_W-1:0]   r_q;
    logic [DIV_D_W-1:0]   r_dvs;
    logic [DIV_D_W:0]     trial;
    logic [DIV_D_W:0]     diff;
    logic                 ge;

    assign trial = {r_rem, r_q[DIV_Q_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign ge    = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(DIV_Q_W);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // high half is below the divisor, so it seeds the remainder
            r_rem <= {{(DIV_D_W-(DIV_N_W-DIV_Q_W)){1'b0}}, i_dividend[DIV_N_W-1:DIV_Q_W]};
            r_q   <= i_dividend[DIV_Q_W-1:0];
            r_dvs <= i_divisor;
        end else if (r_busy && r_cnt != '0) begin
            r_rem <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
            r_q   <= {r_q[DIV_Q_W-2:0], ge};
        end
    end

    assign o_done     = r_busy && (r_cnt == '0);
    assign o_quotient = r_q;
endmodule
`default_nettype wire

/* rtl/core/dmac_ctrl.sv */
// Sequencer of the crossover block: reads, sum update, cross and multiply
// steps, three optional divisions and commit. Depends on dmac_pkg.
`default_nettype none
module dmac_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire dmac_pkg::t_dp_status i_status,
    output dmac_pkg::t_dp_cmd         o_cmd
);
    import dmac_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_RD_S;
                end
            end
            ST_RD_S: begin
                o_cmd.rd_short = 1'b1;
                n_state        = ST_RD_L;
            end
            ST_RD_L: begin
                o_cmd.rd_long = 1'b1;
                n_state       = ST_SUMS;
            end
            ST_SUMS: begin
                o_cmd.upd_sums = 1'b1;
                n_state        = ST_DIV_S;
            end
            ST_DIV_S: begin
                o_cmd.div_sel = DIV_SHORT;
                if (i_status.need_s) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_WAIT_S;
                end else begin
                    n_state = ST_DIV_L;
                end
            end
            ST_WAIT_S: begin
                o_cmd.div_sel = DIV_SHORT;
                if (i_status.div_done) begin
                    o_cmd.take_quot = 1'b1;
                    n_state         = ST_DIV_L;
                end
            end
            ST_DIV_L: begin
                o_cmd.div_sel = DIV_LONG;
                if (i_status.need_l) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_WAIT_L;
                end else begin
                    n_state = ST_CROSS;
                end
            end
            ST_WAIT_L: begin
                o_cmd.div_sel = DIV_LONG;
                if (i_status.div_done) begin
                    o_cmd.take_quot = 1'b1;
                    n_state         = ST_CROSS;
                end
            end
            ST_CROSS: begin
                o_cmd.cross_calc = 1'b1;
                n_state          = ST_PROD;
            end
            ST_PROD: begin
                o_cmd.prod_calc = 1'b1;
                n_state         = ST_DIV_X;
            end
            ST_DIV_X: begin
                o_cmd.div_sel = DIV_CROSS;
                if (i_status.need_x) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_WAIT_X;
                end else begin
                    n_state = ST_COMMIT;
                end
            end
            ST_WAIT_X: begin
                o_cmd.div_sel = DIV_CROSS;
                if (i_status.div_done) begin
                    o_cmd.take_quot = 1'b1;
                    n_state         = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                // hold until the output register is free
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

/* rtl/core/dmac_dp.sv */
// Datapath of the crossover block: sample line memory, running sums,
// window registers, cross arithmetic and output register. Depends on
// dmac_pkg and dmac_div.
`default_nettype none
module dmac_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [dmac_pkg::PRICE_W-1:0]   i_price_sample,
    input  wire logic                           i_cfg_valid,
    input  wire logic [dmac_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [dmac_pkg::WIN_REG_W-1:0] i_cfg_data,
    input  wire dmac_pkg::t_dp_cmd              i_cmd,
    output dmac_pkg::t_dp_status                o_status,
    input  wire logic                           i_out_ready,
    output logic                                o_out_valid,
    output logic [dmac_pkg::PRICE_W-1:0]        o_short_average,
    output logic [dmac_pkg::PRICE_W-1:0]        o_long_average,
    output logic [dmac_pkg::KIND_W-1:0]         o_cross_kind,
    output logic signed [dmac_pkg::PRICE_W-1:0] o_cross_value
);
    import dmac_pkg::*;

    function automatic logic [WIN_W-1:0] eff_win(input logic [WIN_REG_W-1:0] w);
        logic [WIN_W+WIN_REG_W-1:0] wz;
        wz = {{WIN_W{1'b0}}, w};
        if (wz > (WIN_W+WIN_REG_W)'(MAX_WINDOW)) begin
            return WIN_W'(MAX_WINDOW);
        end
        return wz[WIN_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] old_idx(input logic [ADDR_W-1:0] wp,
                                                  input logic [WIN_W-1:0]  w);
        logic [WIN_W:0] a;
        logic [WIN_W:0] b;
        logic [WIN_W:0] r;
        a = {{(WIN_W+1-ADDR_W){1'b0}}, wp};
        b = {1'b0, w};
        if (a >= b) begin
            r = a - b;
        end else begin
            r = a + (WIN_W+1)'(MAX_WINDOW) - b;
        end
        return r[ADDR_W-1:0];
    endfunction

    logic [PRICE_W-1:0]   r_line [MAX_WINDOW];
    logic [WIN_REG_W-1:0] r_short_window;
    logic [WIN_REG_W-1:0] r_long_window;
    logic [WIN_W-1:0]     r_count;
    logic [ADDR_W-1:0]    r_wp;
    logic [SUM_W-1:0]     r_short_sum;
    logic [SUM_W-1:0]     r_long_sum;
    logic [PRICE_W-1:0]   r_prev_s;
    logic [PRICE_W-1:0]   r_prev_l;
    logic [PRICE_W-1:0]   r_x;
    logic [PRICE_W-1:0]   r_rd;
    logic [PRICE_W-1:0]   r_old_s;
    logic [PRICE_W-1:0]   r_s;
    logic [PRICE_W-1:0]   r_l;
    logic [KIND_W-1:0]    r_kind;
    logic [PRICE_W-1:0]   r_adif;
    logic [DIV_D_W-1:0]   r_den;
    logic [PRICE_W-1:0]   r_ad;
    logic                 r_up;
    logic [DIV_N_W-1:0]   r_prod;
    logic [PRICE_W-1:0]   r_lvl;
    logic                 r_out_valid;
    logic [PRICE_W-1:0]   r_o_s;
    logic [PRICE_W-1:0]   r_o_l;
    logic [KIND_W-1:0]    r_o_kind;
    logic [PRICE_W-1:0]   r_o_lvl;

    logic [WIN_W-1:0]     ws;
    logic [WIN_W-1:0]     wl;
    logic [ADDR_W-1:0]    rd_addr;
    logic [SUM_W-1:0]     sub_s;
    logic [SUM_W-1:0]     sub_l;
    logic [WIN_W:0]       cnt_next;
    logic                 div_start;
    logic                 div_done;
    logic [DIV_N_W-1:0]   div_n;
    logic [DIV_D_W-1:0]   div_d;
    logic [DIV_Q_W-1:0]   quot;
    logic signed [PRICE_W:0] dif;
    logic signed [PRICE_W:0] difx;
    logic [PRICE_W:0]     adif;
    logic [PRICE_W:0]     adifx;
    logic signed [LVL_W-1:0] lvl;
    logic                 cfg_hit;

    assign ws       = eff_win(r_short_window);
    assign wl       = eff_win(r_long_window);
    assign rd_addr  = i_cmd.rd_short ? old_idx(r_wp, ws) : old_idx(r_wp, wl);
    assign cnt_next = {1'b0, r_count} + 1'b1;
    assign sub_s    = (r_count >= ws) ? SUM_W'(r_old_s) : '0;
    assign sub_l    = (r_count >= wl) ? SUM_W'(r_rd) : '0;
    assign cfg_hit  = i_cfg_valid &&
                      (i_cfg_index == REG_SHORT_WINDOW || i_cfg_index == REG_LONG_WINDOW);

    assign o_status.need_s   = (ws > WIN_W'(1)) && (cnt_next >= {1'b0, ws});
    assign o_status.need_l   = (wl > WIN_W'(1)) && (cnt_next >= {1'b0, wl});
    assign o_status.need_x   = r_kind != CROSS_NONE;
    assign o_status.div_done = div_done;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_comb begin
        unique case (i_cmd.div_sel)
            DIV_SHORT: begin
                div_n = DIV_N_W'(r_short_sum);
                div_d = DIV_D_W'(ws);
            end
            DIV_LONG: begin
                div_n = DIV_N_W'(r_long_sum);
                div_d = DIV_D_W'(wl);
            end
            DIV_CROSS: begin
                div_n = r_prod;
                div_d = r_den;
            end
            default: begin
                div_n = r_prod;
                div_d = r_den;
            end
        endcase
    end

    assign div_start = i_cmd.div_start;

    dmac_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_n),
        .i_divisor  (div_d),
        .o_done     (div_done),
        .o_quotient (quot)
    );

    assign dif   = $signed({1'b0, r_prev_s}) - $signed({1'b0, r_prev_l});
    assign difx  = $signed({1'b0, r_l}) - $signed({1'b0, r_s});
    assign adif  = dif[PRICE_W] ? {1'b0, PRICE_W'(-dif)} : {1'b0, dif[PRICE_W-1:0]};
    assign adifx = difx[PRICE_W] ? {1'b0, PRICE_W'(-difx)} : {1'b0, difx[PRICE_W-1:0]};
    assign lvl   = r_up ? $signed({2'b00, r_prev_s}) + $signed({2'b00, quot})
                        : $signed({2'b00, r_prev_s}) - $signed({2'b00, quot});

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_line[r_wp] <= r_x;
        end
        if (i_cmd.rd_short || i_cmd.rd_long) begin
            r_rd <= r_line[rd_addr];
        end
    end

    // per-item working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_x <= i_price_sample;
        end
        if (i_cmd.rd_long) begin
            r_old_s <= r_rd;
        end
        if (i_cmd.upd_sums) begin
            r_s <= r_x;
            r_l <= r_x;
        end
        if (i_cmd.take_quot) begin
            unique case (i_cmd.div_sel)
                DIV_SHORT: r_s <= quot;
                DIV_LONG:  r_l <= quot;
                DIV_CROSS: begin
                    if (lvl > LVL_W'(32'sh7fff_ffff)) begin
                        r_lvl <= 32'h7fff_ffff;
                    end else if (lvl < -LVL_W'(33'sh0_8000_0000)) begin
                        r_lvl <= 32'h8000_0000;
                    end else begin
                        r_lvl <= lvl[PRICE_W-1:0];
                    end
                end
                default: r_lvl <= r_lvl;
            endcase
        end
        if (i_cmd.cross_calc) begin
            r_kind <= CROSS_NONE;
            if (r_count != '0) begin
                if (dif < 0 && difx < 0) begin
                    r_kind <= CROSS_UP;
                end else if (dif > 0 && difx > 0) begin
                    r_kind <= CROSS_DOWN;
                end
            end
            r_adif <= adif[PRICE_W-1:0];
            r_den  <= DIV_D_W'(adif) + DIV_D_W'(adifx);
            r_up   <= r_s >= r_prev_s;
            r_ad   <= (r_s >= r_prev_s) ? r_s - r_prev_s : r_prev_s - r_s;
            r_lvl  <= '0;
        end
        if (i_cmd.prod_calc) begin
            r_prod <= {{(DIV_N_W-PRICE_W){1'b0}}, r_ad} * {{(DIV_N_W-PRICE_W){1'b0}}, r_adif};
        end
    end

    // block state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_window <= '0;
            r_long_window  <= '0;
            r_count        <= '0;
            r_wp           <= '0;
            r_short_sum    <= '0;
            r_long_sum     <= '0;
            r_prev_s       <= '0;
            r_prev_l       <= '0;
        end else begin
            if (i_cmd.upd_sums) begin
                // wraps in SUM_W bits; the difference always fits
                r_short_sum <= (ws == '0) ? '0 : r_short_sum + SUM_W'(r_x) - sub_s;
                r_long_sum  <= (wl == '0) ? '0 : r_long_sum + SUM_W'(r_x) - sub_l;
            end
            if (i_cmd.commit) begin
                r_wp <= (r_wp == ADDR_W'(MAX_WINDOW - 1)) ? '0 : r_wp + 1'b1;
                if (r_count != WIN_W'(MAX_WINDOW)) begin
                    r_count <= r_count + 1'b1;
                end
                r_prev_s <= r_s;
                r_prev_l <= r_l;
            end
            if (cfg_hit) begin
                if (i_cfg_index == REG_SHORT_WINDOW) begin
                    r_short_window <= i_cfg_data;
                end else begin
                    r_long_window <= i_cfg_data;
                end
                r_count     <= '0;
                r_short_sum <= '0;
                r_long_sum  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_o_s    <= r_s;
            r_o_l    <= r_l;
            r_o_kind <= r_kind;
            r_o_lvl  <= r_lvl;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_short_average = r_o_s;
    assign o_long_average  = r_o_l;
    assign o_cross_kind    = r_o_kind;
    assign o_cross_value   = $signed(r_o_lvl);
endmodule
`default_nettype wire

/* rtl/core/dmac_chk.sv */
// Port-level checker for the crossover block and its bind to the top level.
// Depends on dmac_pkg.
`default_nettype none
module dmac_chk (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_in_valid,
    input wire logic                                i_in_ready,
    input wire logic                                i_out_valid,
    input wire logic                                i_out_ready,
    input wire logic [dmac_pkg::KIND_W-1:0]         i_cross_kind,
    input wire logic signed [dmac_pkg::PRICE_W-1:0] i_cross_value
);
    import dmac_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second request taken while a sample is in work");

    a_kind_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_cross_kind == CROSS_NONE || i_cross_kind == CROSS_UP ||
                         i_cross_kind == CROSS_DOWN))
        else $error("bad cross kind");

    a_no_cross_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_cross_kind == CROSS_NONE |-> i_cross_value == '0)
        else $error("crossing level nonzero without a cross");
endmodule

bind dual_moving_average_crossover dmac_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_cross_kind  (o_out.cross_kind),
    .i_cross_value (o_out.cross_value)
);
`default_nettype wire

/* tb/sv/dual_moving_average_crossover_test.sv */
// Self-checking testbench for dual_moving_average_crossover.
// Depends on dmac_pkg, dmac_ifs and the block itself; predicts every result
// from its own window-sum model and compares it with the output channel.
module dual_moving_average_crossover_test;
    timeunit 1ns;
    timeprecision 1ps;
    import dmac_pkg::*;

    typedef struct packed {
        logic [31:0]        short_avg;
        logic [31:0]        long_avg;
        logic [1:0]         kind;
        logic signed [31:0] level;
    } avg_result_t;

    typedef struct packed {
        bit          is_cfg;
        logic [7:0]  index;
        logic [31:0] data;
    } request_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    dmac_in_if  in_ch();
    dmac_out_if out_ch();
    dmac_cfg_if cfg_ch();

    dual_moving_average_crossover dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch), .i_cfg(cfg_ch)
    );

    // predictor state
    logic [31:0] line_mem [MAX_WINDOW];
    logic [63:0] sum_s, sum_l;
    int unsigned count_held, wpos, win_s, win_l;
    logic [31:0] prev_s, prev_l;

    request_t    pending_q[$];
    avg_result_t expected_q[$];
    int          errors = 0;
    int          sent_samples = 0;
    longint      cycles = 0;
    int          hold_cycles = 0;
    bit          long_hold_req = 1'b0;

    function automatic int unsigned clamp_win(int unsigned w);
        return (w > MAX_WINDOW) ? MAX_WINDOW : w;
    endfunction

    task automatic window_avg(inout logic [63:0] sum, input int unsigned wreg,
                              input logic [31:0] x, output logic [31:0] avg);
        int unsigned w, idx;
        w = clamp_win(wreg);
        if (w == 0) begin
            sum = 0;
            avg = x;
            return;
        end
        sum += x;
        if (count_held >= w) begin
            idx = (wpos >= w) ? wpos - w : wpos + MAX_WINDOW - w;
            sum -= line_mem[idx];
        end
        if (w == 1 || count_held + 1 < w) avg = x;
        else avg = 32'(sum / w);
    endtask

    task automatic predict_sample(input logic [31:0] x);
        avg_result_t r;
        longint dif, difx, lvl;
        longint unsigned adif, adifx, den, ad, q;
        bit up;
        window_avg(sum_s, win_s, x, r.short_avg);
        window_avg(sum_l, win_l, x, r.long_avg);
        r.kind = CROSS_NONE;
        lvl = 0;
        if (count_held > 0) begin
            dif  = longint'(prev_s) - longint'(prev_l);
            difx = longint'(r.long_avg) - longint'(r.short_avg);
            if (dif < 0 && difx < 0) r.kind = CROSS_UP;
            else if (dif > 0 && difx > 0) r.kind = CROSS_DOWN;
            if (r.kind != CROSS_NONE) begin
                adif  = (dif < 0) ? -dif : dif;
                adifx = (difx < 0) ? -difx : difx;
                den = adif + adifx;
                up = r.short_avg >= prev_s;
                ad = up ? r.short_avg - prev_s : prev_s - r.short_avg;
                q = (den != 0) ? (ad * adif) / den : 0;
                lvl = up ? longint'(prev_s) + longint'(q) : longint'(prev_s) - longint'(q);
                if (lvl > 64'sd2147483647) lvl = 64'sd2147483647;
                if (lvl < -64'sd2147483648) lvl = -64'sd2147483648;
            end
        end
        r.level = 32'(lvl);
        line_mem[wpos] = x;
        wpos = (wpos + 1 >= MAX_WINDOW) ? 0 : wpos + 1;
        if (count_held < MAX_WINDOW) count_held++;
        prev_s = r.short_avg;
        prev_l = r.long_avg;
        expected_q.push_back(r);
    endtask

    task automatic apply_window(input logic [7:0] index, input logic [7:0] value);
        if (index == REG_SHORT_WINDOW) win_s = value;
        else if (index == REG_LONG_WINDOW) win_l = value;
        else return;
        count_held = 0;
        sum_s = 0;
        sum_l = 0;
    endtask

    function automatic int pick_gap();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 120)
                                            : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3));
    endfunction

    // driver: samples go on the input channel, window writes on the cfg channel
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid  <= 1'b0;
            cfg_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_sample(in_ch.price_sample);
                sent_samples++;
            end
            if (cfg_ch.valid && cfg_ch.ready) apply_window(cfg_ch.index, cfg_ch.data[7:0]);
            if ((in_ch.valid && !in_ch.ready) || (cfg_ch.valid && !cfg_ch.ready)) begin
                // hold the current request
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                in_ch.valid  <= 1'b0;
                cfg_ch.valid <= 1'b0;
            end else if (pending_q.size() > 0 && !(pending_q[0].is_cfg &&
                         (expected_q.size() > 0 || in_ch.valid))) begin
                request_t rq;
                rq = pending_q.pop_front();
                in_ch.valid  <= !rq.is_cfg;
                cfg_ch.valid <= rq.is_cfg;
                in_ch.price_sample <= rq.data;
                cfg_ch.index <= rq.index;
                cfg_ch.data  <= rq.data[7:0];
                send_gap <= (rq.is_cfg || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
            end else begin
                in_ch.valid  <= 1'b0;
                cfg_ch.valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stalls
    int recv_gap = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result short=%h long=%h", $realtime,
                             out_ch.short_average, out_ch.long_average);
                    errors++;
                end else begin
                    avg_result_t e;
                    e = expected_q.pop_front();
                    if (out_ch.short_average !== e.short_avg) begin
                        $display("%0t: short_average exp %h got %h", $realtime,
                                 e.short_avg, out_ch.short_average);
                        errors++;
                    end
                    if (out_ch.long_average !== e.long_avg) begin
                        $display("%0t: long_average exp %h got %h", $realtime,
                                 e.long_avg, out_ch.long_average);
                        errors++;
                    end
                    if (out_ch.cross_kind !== e.kind) begin
                        $display("%0t: cross_kind exp %0d got %0d", $realtime,
                                 e.kind, out_ch.cross_kind);
                        errors++;
                    end
                    if (out_ch.cross_value !== e.level) begin
                        $display("%0t: cross_value exp %0d got %0d", $realtime,
                                 e.level, out_ch.cross_value);
                        errors++;
                    end
                end
            end
            if (long_hold_req && hold_cycles == 0) begin
                hold_cycles <= 2000;
                long_hold_req <= 1'b0;
                out_ch.ready <= 1'b0;
            end else if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                out_ch.ready <= (hold_cycles == 1);
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                out_ch.ready <= (recv_gap == 1);
            end else if ($urandom_range(0, 4) == 0) begin
                recv_gap <= pick_gap();
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > 3000000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic queue_sample(input logic [31:0] x);
        pending_q.push_back('{is_cfg: 1'b0, index: 8'd0, data: x});
    endtask

    task automatic queue_window(input logic [7:0] index, input logic [7:0] value);
        pending_q.push_back('{is_cfg: 1'b1, index: index, data: {24'd0, value}});
    endtask

    // random walk around a level so the averages cross often
    task automatic queue_walk(input int n, input logic [31:0] start, input int step);
        longint p;
        p = start;
        for (int i = 0; i < n; i++) begin
            p += $signed($urandom_range(0, 2 * step)) - step;
            if (p < 0) p = 0;
            if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
            queue_sample(32'(p));
        end
    endtask

    int unsigned ws, wl;
    initial begin
        in_ch.valid = 1'b0;
        in_ch.price_sample = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        out_ch.ready = 1'b0;
        sum_s = 0; sum_l = 0; count_held = 0; wpos = 0;
        win_s = 0; win_l = 0; prev_s = 0; prev_l = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: pass-through, extremes, windows 1, 2 and above the maximum
        queue_sample(32'h0);
        queue_sample(32'hFFFF_FFFF);
        queue_sample(32'h0);
        queue_sample(32'h8000_0000);
        queue_window(REG_SHORT_WINDOW, 8'd1);
        queue_window(REG_LONG_WINDOW, 8'd2);
        queue_sample(32'hFFFF_FFFF);
        queue_sample(32'h0);
        queue_sample(32'hFFFF_FFFF);
        queue_sample(32'h0);
        queue_sample(32'h7FFF_FFFF);
        queue_window(REG_SHORT_WINDOW, 8'd2);
        queue_window(REG_LONG_WINDOW, 8'd255);
        for (int i = 0; i < 6; i++) queue_sample(i[0] ? 32'hFFFF_FFFF : 32'h1);
        queue_window(REG_SHORT_WINDOW, 8'd3);
        queue_window(REG_LONG_WINDOW, 8'd5);
        queue_walk(8, 32'h0000_1000, 4000);

        // random phases with fresh window settings
        while (sent_samples < 23 || pending_q.size() > 0) @(posedge i_clk);
        for (int ph = 0; ph < 14; ph++) begin
            while (expected_q.size() > 0 || pending_q.size() > 0) @(posedge i_clk);
            repeat (150) @(posedge i_clk);
            case (ph)
                0: begin ws = 128; wl = 128; end
                1: begin ws = 0;   wl = 128; end
                2: begin ws = 200; wl = 7;   end
                default: begin
                    ws = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(2, 12);
                    wl = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(2, 24);
                end
            endcase
            queue_window(REG_SHORT_WINDOW, 8'(ws));
            queue_window(REG_LONG_WINDOW, 8'(wl));
            if (ph == 1) long_hold_req = 1'b1;
            if (ph == 0 || ph == 1) queue_walk(180, $urandom, 1 << $urandom_range(4, 28));
            else if ($urandom_range(0, 3) == 0)
                for (int i = 0; i < 40; i++) queue_sample($urandom);
            else queue_walk(45, $urandom, 1 << $urandom_range(2, 30));
        end

        while (pending_q.size() > 0 || expected_q.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
